[hdl/cfd_pkg.sv]
`timescale 1ns / 1ps

package cfd_pkg;

    // Fixed field widths
    localparam int BYTE_W   = 8;
    localparam int STATUS_W = 3;
    localparam int LEN_W    = 13;
    localparam int CFG_W    = 13;

    // Configuration register indexes
    localparam logic REG_MAX_ENC = 1'b0;
    localparam logic REG_MAX_DEC = 1'b1;

    // Configuration reset values
    localparam logic [CFG_W-1:0] MAX_ENC_RESET = 13'd4096;
    localparam logic [CFG_W-1:0] MAX_DEC_RESET = 13'd4000;

    // Input word kinds
    localparam logic KIND_BYTE  = 1'b0;
    localparam logic KIND_FLUSH = 1'b1;

    // Result word kinds
    localparam logic RES_DATA = 1'b0;
    localparam logic RES_END  = 1'b1;

    // Frame status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_TRUNC    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_DEC_LONG = 3'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_ENC_LONG = 3'd4;
    localparam logic [STATUS_W-1:0] ST_FLUSHED  = 3'd5;

    // Special byte values
    localparam logic [BYTE_W-1:0] BYTE_DELIM = 8'h00;
    localparam logic [BYTE_W-1:0] BYTE_FULL  = 8'hFF;

    // Depth of the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic              kind;
        logic [BYTE_W-1:0] byte_value;
    } in_word_t;

    typedef struct packed {
        logic                result_kind;
        logic [BYTE_W-1:0]   out_byte;
        logic [STATUS_W-1:0] frame_status;
        logic [LEN_W-1:0]    frame_length;
    } out_word_t;

    // Classified action handed from front to back
    typedef struct packed {
        logic                is_end;
        logic [BYTE_W-1:0]   data;
        logic [STATUS_W-1:0] status;
        logic [LEN_W-1:0]    length;
    } op_t;

endpackage

[hdl/cfd_front.sv]
`timescale 1ns / 1ps

module cfd_front #(
    parameter int FRAME_BYTES = 4096
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [12:0]         cfg_data,
    input  logic                accept,
    input  cfd_pkg::in_word_t   in_word,
    output logic                push,
    output cfd_pkg::op_t        op
);
    import cfd_pkg::*;

    localparam int ENC_W = $clog2(FRAME_BYTES + 1);
    localparam int CMP_W = (ENC_W > CFG_W) ? ENC_W : CFG_W;

    logic [CFG_W-1:0]    max_enc_reg;
    logic [CFG_W-1:0]    max_dec_reg;
    logic [ENC_W-1:0]    enc_cnt_reg,    enc_cnt_next;
    logic [BYTE_W-1:0]   block_left_reg, block_left_next;
    logic                block_full_reg, block_full_next;
    logic                zero_pend_reg,  zero_pend_next;
    logic [LEN_W-1:0]    dec_cnt_reg,    dec_cnt_next;
    logic [STATUS_W-1:0] fault_reg,      fault_next;

    logic [CMP_W-1:0]    max_enc_ext;
    logic [CMP_W-1:0]    enc_lim;
    logic [CMP_W-1:0]    enc_ext;
    logic                emit;
    logic                want_data;
    logic [BYTE_W-1:0]   data_val;
    logic [BYTE_W-1:0]   left_dec;

    // Clamp the encoded limit to 1 .. FRAME_BYTES
    always_comb
    begin
        max_enc_ext = CMP_W'(max_enc_reg);
        enc_ext     = CMP_W'(enc_cnt_reg);
        if (max_enc_ext == '0)
        begin
            enc_lim = CMP_W'(1);
        end
        else if (max_enc_ext > CMP_W'(FRAME_BYTES))
        begin
            enc_lim = CMP_W'(FRAME_BYTES);
        end
        else
        begin
            enc_lim = max_enc_ext;
        end
    end

    // Classify the word and advance the frame state
    always_comb
    begin
        enc_cnt_next    = enc_cnt_reg;
        block_left_next = block_left_reg;
        block_full_next = block_full_reg;
        zero_pend_next  = zero_pend_reg;
        dec_cnt_next    = dec_cnt_reg;
        fault_next      = fault_reg;
        emit            = 1'b0;
        want_data       = 1'b0;
        data_val        = in_word.byte_value;
        left_dec        = block_left_reg - 8'd1;
        op.is_end       = RES_DATA;
        op.data         = in_word.byte_value;
        op.status       = ST_OK;
        op.length       = dec_cnt_reg;

        if (in_word.kind == KIND_FLUSH)
        begin
            if (enc_cnt_reg != '0)
            begin
                emit      = 1'b1;
                op.is_end = RES_END;
                op.status = ST_FLUSHED;
            end
        end
        else if (in_word.byte_value == BYTE_DELIM)
        begin
            if (enc_cnt_reg != '0)
            begin
                emit      = 1'b1;
                op.is_end = RES_END;
                if (fault_reg != ST_OK)
                begin
                    op.status = fault_reg;
                end
                else if (block_left_reg != '0)
                begin
                    op.status = ST_TRUNC;
                end
                else if (dec_cnt_reg == '0)
                begin
                    op.status = ST_EMPTY;
                end
                else
                begin
                    op.status = ST_OK;
                end
            end
        end
        else if (enc_ext >= enc_lim)
        begin
            // Drop the overflowing byte and end the frame
            emit      = 1'b1;
            op.is_end = RES_END;
            op.status = ST_ENC_LONG;
        end
        else
        begin
            enc_cnt_next = enc_cnt_reg + ENC_W'(1);
            if (block_left_reg != '0)
            begin
                want_data       = 1'b1;
                data_val        = in_word.byte_value;
                block_left_next = left_dec;
                if (left_dec == '0 && !block_full_reg)
                begin
                    zero_pend_next = 1'b1;
                end
            end
            else
            begin
                if (zero_pend_reg)
                begin
                    want_data = 1'b1;
                    data_val  = BYTE_DELIM;
                end
                zero_pend_next  = 1'b0;
                block_left_next = in_word.byte_value - 8'd1;
                block_full_next = (in_word.byte_value == BYTE_FULL);
                if (in_word.byte_value == 8'd1)
                begin
                    zero_pend_next = 1'b1;
                end
            end

            // Emit a decoded byte unless the frame is faulted or full
            if (want_data && fault_reg == ST_OK)
            begin
                if (dec_cnt_reg >= max_dec_reg)
                begin
                    fault_next = ST_DEC_LONG;
                end
                else
                begin
                    dec_cnt_next = dec_cnt_reg + LEN_W'(1);
                    emit         = 1'b1;
                    op.data      = data_val;
                end
            end
        end

        // Any frame end or flush starts a fresh frame
        if (in_word.kind == KIND_FLUSH || op.is_end == RES_END)
        begin
            enc_cnt_next    = '0;
            block_left_next = '0;
            block_full_next = 1'b0;
            zero_pend_next  = 1'b0;
            dec_cnt_next    = '0;
            fault_next      = ST_OK;
        end
    end

    assign push = accept && emit;

    // Hold configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_enc_reg <= MAX_ENC_RESET;
            max_dec_reg <= MAX_DEC_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_MAX_ENC)
            begin
                max_enc_reg <= cfg_data;
            end
            else
            begin
                max_dec_reg <= cfg_data;
            end
        end
    end

    // Advance frame state on each accepted word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enc_cnt_reg    <= '0;
            block_left_reg <= '0;
            block_full_reg <= 1'b0;
            zero_pend_reg  <= 1'b0;
            dec_cnt_reg    <= '0;
            fault_reg      <= ST_OK;
        end
        else if (accept)
        begin
            enc_cnt_reg    <= enc_cnt_next;
            block_left_reg <= block_left_next;
            block_full_reg <= block_full_next;
            zero_pend_reg  <= zero_pend_next;
            dec_cnt_reg    <= dec_cnt_next;
            fault_reg      <= fault_next;
        end
    end

endmodule

[hdl/cfd_queue.sv]
`timescale 1ns / 1ps

module cfd_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  cfd_pkg::op_t  push_op,
    input  logic          pop,
    output logic          full,
    output logic          not_empty,
    output cfd_pkg::op_t  head_op
);
    import cfd_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    op_t              slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg,  count_next;

    assign full      = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_op   = slot_reg[rd_ptr_reg];

    // Advance pointers and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed action
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule

[hdl/cfd_back.sv]
`timescale 1ns / 1ps

module cfd_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               avail,
    input  cfd_pkg::op_t       head_op,
    input  logic               out_stall,
    output logic               pop,
    output logic               out_valid,
    output cfd_pkg::out_word_t out_word
);
    import cfd_pkg::*;

    logic      out_valid_reg, out_valid_next;
    out_word_t out_word_reg,  out_word_next;
    logic      load;

    // Load a new word when the output is empty or being taken
    assign load = avail && (!out_valid_reg || !out_stall);
    assign pop  = load;

    // Format the result word from the action
    always_comb
    begin
        out_word_next = out_word_reg;
        if (load)
        begin
            out_word_next.result_kind  = head_op.is_end;
            out_word_next.out_byte     = head_op.is_end ? '0 : head_op.data;
            out_word_next.frame_status = head_op.is_end ? head_op.status : ST_OK;
            out_word_next.frame_length = head_op.is_end ? head_op.length : '0;
        end
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_word_reg <= out_word_next;
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

endmodule

[hdl/cobs_frame_decoder_top.sv]
`timescale 1ns / 1ps

// Streaming COBS frame decoder.
// Input channel (in_valid/in_stall/in_word): one received byte or a flush
// event per word. Output channel (out_valid/out_stall/out_word): decoded data
// bytes and one frame-end word, carrying the decoded length and a status, at
// each delimiter or flush ending a nonempty frame and at encoded overflow;
// the consumer drops frames not ok. Configuration port (cfg_we/cfg_index/
// cfg_data): index 0 sets the encoded byte limit, index 1 the decoded byte
// limit; write only while idle. Throughput: one word per cycle while the
// queue is not full; the front stage updates its frame state combinationally.
// An accepted word is classified combinationally in the front stage and
// pushed into the queue when accepted; the queue head moves into the output
// register when the output register is empty or not stalled.
// A two-entry queue sits between the front stage and the output register;
// when out_stall holds, the queue fills and in_stall rises once it is full.
// The output word is held stable while stalled.
// Reset clears the frame state and the output, and sets the limits to 4096
// encoded and 4000 decoded bytes.
module cobs_frame_decoder_top #(
    parameter int FRAME_BYTES = 4096
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [12:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  cfd_pkg::in_word_t  in_word,
    output logic               out_valid,
    input  logic               out_stall,
    output cfd_pkg::out_word_t out_word
);
    import cfd_pkg::*;

    logic accept;
    logic push;
    logic pop;
    logic q_full;
    logic q_avail;
    op_t  push_op;
    op_t  head_op;

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;

    cfd_front #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .in_word   (in_word),
        .push      (push),
        .op        (push_op)
    );

    cfd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_op   (push_op),
        .pop       (pop),
        .full      (q_full),
        .not_empty (q_avail),
        .head_op   (head_op)
    );

    cfd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .avail     (q_avail),
        .head_op   (head_op),
        .out_stall (out_stall),
        .pop       (pop),
        .out_valid (out_valid),
        .out_word  (out_word)
    );

endmodule

[hdl/cfd_checker.sv]
`timescale 1ns / 1ps

module cfd_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input cfd_pkg::out_word_t out_word
);
    import cfd_pkg::*;

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_word))
        else $error("stalled output word changed");

    // Input is never stalled while the output stage is empty
    a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input stalled with empty output");

    // Data words carry no status and no length
    a_data_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_word.result_kind == RES_DATA |->
            out_word.frame_status == ST_OK && out_word.frame_length == '0)
        else $error("data word with status or length");

    // An ok frame decoded something, an empty frame nothing
    a_ok_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_word.result_kind == RES_END &&
            out_word.frame_status == ST_OK |-> out_word.frame_length != '0)
        else $error("ok frame with zero length");

    a_empty_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_word.result_kind == RES_END &&
            out_word.frame_status == ST_EMPTY |-> out_word.frame_length == '0)
        else $error("empty frame with nonzero length");

endmodule

bind cobs_frame_decoder_top cfd_checker u_cfd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
);
